// ===== sv/mbrtu_pkg.sv =====
// Package for the Modbus RTU holding register slave.
// Word types, frame constants and the CRC-16/Modbus byte update.
// No dependencies.
package mbrtu_pkg;

    localparam int MAX_FRAME = 64;
    localparam int NUM_REGS  = 10;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int HEAD_LEN  = 8;
    localparam int READ_LEN  = 7;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FN_READ         = 8'h03;
    localparam logic [7:0]  FN_WRITE        = 8'h06;
    localparam logic [7:0]  READ_BYTE_COUNT = 8'h02;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_out_word;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/modbus_rtu_holding_register_slave_unit.sv =====
// Top level of the Modbus RTU holding register slave.
// Frame parsing, register memory and reply sequencer; uses mbrtu_pkg.
//
// channel  | signals                                  | word
// ---------+------------------------------------------+------------
// rx in    | i_in_valid, o_in_ready, i_in_word        | t_in_word
// tx out   | o_out_valid, i_out_ready, o_out_word     | t_out_word
// config   | i_cfg_we, i_cfg_wdata                    | 8-bit addr
//
// One received word per cycle while o_in_ready is high. A frame-closing word starts a
// register memory read; reply words leave the transmit buffer up to one per cycle.
// A reply waits in a holding stage while the previous one is sent; a closing word
// waits only while that stage is full.
// Reset clears the per-entry valid bits at once; no clearing pass.
module modbus_rtu_holding_register_slave_unit
    import mbrtu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic [7:0]       r_dev;
    logic [CNT_W-1:0] r_count;
    logic [15:0]      r_tail;
    logic [15:0]      r_crc;
    logic [7:0]       r_head [HEAD_LEN];

    logic [15:0]      r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [15:0]      r_rdata;
    logic             r_rd_vld;

    logic             r_b_valid;
    logic             r_b_write;
    logic [REG_AW-1:0] r_b_reg;
    logic [7:0]       r_b_head [HEAD_LEN];

    logic             r_tx_busy;
    logic             r_tx_write;
    logic [2:0]       r_tx_idx;
    logic [15:0]      r_tx_crc;
    logic [7:0]       r_tx_buf [HEAD_LEN];

    logic             in_acc;
    logic             out_acc;
    logic             closing;
    logic             tx_load;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      n_crc;
    logic [15:0]      n_tail;
    logic [15:0]      reg_idx;
    logic             fn_ok;
    logic             frame_ok;
    logic [7:0]       head7;
    logic [15:0]      rd_val;
    logic [2:0]       last_idx;
    logic [7:0]       tx_byte;

    assign closing  = i_in_word.frame_end || (r_count == CNT_W'(MAX_FRAME - 1));
    assign o_in_ready = !(closing && r_b_valid);
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = o_out_valid && i_out_ready;
    assign tx_load  = r_b_valid && (!r_tx_busy || (out_acc && (r_tx_idx == last_idx)));

    assign cnt_inc  = r_count + CNT_W'(1);
    assign n_crc    = (r_count >= CNT_W'(2)) ? crc_feed(r_crc, r_tail[7:0]) : r_crc;
    assign n_tail   = {i_in_word.rx_byte, r_tail[15:8]};
    assign reg_idx  = {r_head[2], r_head[3]};
    assign fn_ok    = (r_head[1] == FN_WRITE)
                   || ((r_head[1] == FN_READ) && (r_head[4] == 8'h00) && (r_head[5] == 8'h01));
    assign frame_ok = (cnt_inc >= CNT_W'(HEAD_LEN)) && (r_head[0] == r_dev)
                   && (n_crc == n_tail) && (reg_idx < 16'(NUM_REGS)) && fn_ok;
    assign head7    = (cnt_inc == CNT_W'(HEAD_LEN)) ? i_in_word.rx_byte : r_head[7];
    assign rd_val   = r_rd_vld ? r_rdata : 16'h0000;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev     <= 8'h01;
            r_count   <= '0;
            r_tail    <= '0;
            r_crc     <= CRC_INIT;
            r_vld     <= '0;
            r_b_valid <= 1'b0;
            r_tx_busy <= 1'b0;
            r_tx_idx  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dev <= i_cfg_wdata;
            end
            if (in_acc) begin
                if (closing) begin
                    r_count <= '0;
                    r_tail  <= '0;
                    r_crc   <= CRC_INIT;
                end else begin
                    r_count <= cnt_inc;
                    r_tail  <= n_tail;
                    r_crc   <= n_crc;
                end
            end
            if (in_acc && closing && frame_ok) begin
                r_b_valid <= 1'b1;
            end else if (tx_load) begin
                r_b_valid <= 1'b0;
            end
            if (tx_load) begin
                if (r_b_write) begin
                    r_vld[r_b_reg] <= 1'b1;
                end
                r_tx_busy <= 1'b1;
                r_tx_idx  <= '0;
            end else if (out_acc) begin
                if (r_tx_idx == last_idx) begin
                    r_tx_busy <= 1'b0;
                end else begin
                    r_tx_idx <= r_tx_idx + 3'd1;
                end
            end
        end
    end

    // payload and register memory; a write lands before the next read samples the memory
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_count < CNT_W'(HEAD_LEN))) begin
            r_head[r_count[2:0]] <= i_in_word.rx_byte;
        end
        if (in_acc && closing) begin
            r_rdata   <= r_mem[reg_idx[REG_AW-1:0]];
            r_rd_vld  <= r_vld[reg_idx[REG_AW-1:0]];
            r_b_write <= (r_head[1] == FN_WRITE);
            r_b_reg   <= reg_idx[REG_AW-1:0];
            for (int i = 0; i < HEAD_LEN - 1; i++) begin
                r_b_head[i] <= r_head[i];
            end
            r_b_head[7] <= head7;
        end
        if (tx_load) begin
            r_tx_write <= r_b_write;
            r_tx_crc   <= CRC_INIT;
            if (r_b_write) begin
                r_mem[r_b_reg] <= {r_b_head[4], r_b_head[5]};
                for (int i = 0; i < HEAD_LEN; i++) begin
                    r_tx_buf[i] <= r_b_head[i];
                end
            end else begin
                r_tx_buf[0] <= r_b_head[0];
                r_tx_buf[1] <= FN_READ;
                r_tx_buf[2] <= READ_BYTE_COUNT;
                r_tx_buf[3] <= rd_val[15:8];
                r_tx_buf[4] <= rd_val[7:0];
                r_tx_buf[5] <= 8'h00;
                r_tx_buf[6] <= 8'h00;
                r_tx_buf[7] <= 8'h00;
            end
        end else if (out_acc && (r_tx_idx < 3'd5)) begin
            r_tx_crc <= crc_feed(r_tx_crc, tx_byte);
        end
    end

    always_comb begin
        last_idx = r_tx_write ? 3'(HEAD_LEN - 1) : 3'(READ_LEN - 1);
        if (r_tx_write || (r_tx_idx < 3'd5)) begin
            tx_byte = r_tx_buf[r_tx_idx];
        end else if (r_tx_idx == 3'd5) begin
            tx_byte = r_tx_crc[7:0];
        end else begin
            tx_byte = r_tx_crc[15:8];
        end
    end

    assign o_out_valid          = r_tx_busy;
    assign o_out_word.tx_byte   = tx_byte;
    assign o_out_word.last_byte = (r_tx_idx == last_idx);

endmodule

// ===== sv/mbrtu_checker.sv =====
// Port-level checks for the Modbus RTU holding register slave.
// Bound to modbus_rtu_holding_register_slave_unit; uses mbrtu_pkg.
module mbrtu_checker
    import mbrtu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("reply word dropped or changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("reply word shown right after reset");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_word.last_byte
            |=> !o_out_valid || !o_out_word.last_byte)
        else $error("reply continues past its last word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid || $past(i_in_valid && o_in_ready))
        else $error("input stalled with no reply pending");

endmodule

bind modbus_rtu_holding_register_slave_unit mbrtu_checker u_mbrtu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for modbus_rtu_holding_register_slave_unit: sends request frames
// and checks every reply word against a built-in slave model or the echoed request.
// Depends on mbrtu_pkg and the slave top level only.
module tb_top;
    import mbrtu_pkg::*;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PLAN_ROWS     = 20;
    localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
    localparam logic [7:0]  FN_ALL_ONES    = 8'hFF;

    typedef enum logic [1:0] {
        REPLY_MODEL,
        REPLY_NONE,
        REPLY_ECHO
    } t_reply_src;

    typedef struct packed {
        logic [7:0]  addr;
        logic [7:0]  fn;
        logic [15:0] reg_idx;
        logic [15:0] data;
        logic [6:0]  len;
        logic        crc_ok;
        logic        close_flag;
        t_reply_src  src;
    } t_frame_row;

    localparam t_frame_row PLAN [PLAN_ROWS] = '{
        '{8'h01, FN_READ,        16'h0000, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_MODEL},
        '{8'h01, FN_WRITE,       16'h0000, 16'hFFFF, 7'd8,  1'b1, 1'b1, REPLY_ECHO},
        '{8'h01, FN_READ,        16'h0000, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_MODEL},
        '{8'h01, FN_WRITE,       16'h0009, 16'h8001, 7'd8,  1'b1, 1'b1, REPLY_ECHO},
        '{8'h01, FN_READ,        16'h0009, 16'h0001, 7'd9,  1'b1, 1'b1, REPLY_MODEL},
        '{8'h01, FN_WRITE,       16'h0003, 16'h1234, 7'd12, 1'b1, 1'b1, REPLY_ECHO},
        '{8'h01, FN_WRITE,       16'h0001, 16'h5555, 7'd7,  1'b1, 1'b1, REPLY_NONE},
        '{8'h01, FN_READ,        16'h0000, 16'h0001, 7'd1,  1'b1, 1'b1, REPLY_NONE},
        '{8'h00, FN_WRITE,       16'h0001, 16'h2222, 7'd8,  1'b1, 1'b1, REPLY_NONE},
        '{8'hFF, FN_READ,        16'h0000, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_NONE},
        '{8'h01, FN_WRITE,       16'h0001, 16'h3333, 7'd8,  1'b0, 1'b1, REPLY_NONE},
        '{8'h01, FN_READ,        16'h000A, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_NONE},
        '{8'h01, FN_WRITE_MULTI, 16'h0001, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_NONE},
        '{8'h01, FN_ALL_ONES,    16'h0000, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_NONE},
        '{8'h01, FN_READ,        16'h0000, 16'h0000, 7'd8,  1'b1, 1'b1, REPLY_NONE},
        '{8'h01, FN_READ,        16'h0000, 16'h0002, 7'd8,  1'b1, 1'b1, REPLY_NONE},
        '{8'h01, FN_READ,        16'h0001, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_MODEL},
        '{8'h01, FN_WRITE,       16'h0005, 16'hA5A5, 7'd64, 1'b1, 1'b0, REPLY_ECHO},
        '{8'h01, FN_READ,        16'h0005, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_MODEL},
        '{8'h01, FN_READ,        16'h0003, 16'h0001, 7'd8,  1'b1, 1'b1, REPLY_MODEL}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;

    // slave model state
    logic [7:0]  station_addr;
    logic [7:0]  head_copy [8];
    logic [15:0] tail_copy;
    logic [15:0] crc_copy;
    int          frame_cnt;
    logic [15:0] regs_copy [NUM_REGS];

    t_out_word   reply_due_q [$];
    t_out_word   due;
    int          err_count   = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;

    logic [7:0]  frame_bytes [MAX_FRAME];
    int          frame_len;
    logic        frame_close;

    modbus_rtu_holding_register_slave_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic void push_reply(input logic [7:0] b, input logic last);
        t_out_word w;
        w.tx_byte   = b;
        w.last_byte = last;
        reply_due_q.push_back(w);
    endfunction

    // advance the slave model by one received byte; queue the reply if keep is set
    function automatic void absorb_rx_byte(input logic [7:0] b, input logic fe, input bit keep);
        logic [15:0] reg_no;
        logic [15:0] val;
        logic [15:0] c;
        logic [7:0]  rsp [5];
        if (frame_cnt >= 2) begin
            crc_copy = crc16_step(crc_copy, tail_copy[7:0]);
        end
        tail_copy = {b, tail_copy[15:8]};
        if (frame_cnt < 8) begin
            head_copy[frame_cnt] = b;
        end
        frame_cnt++;
        if (fe || frame_cnt >= MAX_FRAME) begin
            reg_no = {head_copy[2], head_copy[3]};
            if (frame_cnt >= 8 && head_copy[0] == station_addr && crc_copy == tail_copy
                    && reg_no < NUM_REGS) begin
                if (head_copy[1] == FN_READ && head_copy[4] == 8'h00 && head_copy[5] == 8'h01) begin
                    val = regs_copy[reg_no];
                    rsp = '{station_addr, FN_READ, READ_BYTE_COUNT, val[15:8], val[7:0]};
                    c = CRC_INIT;
                    for (int i = 0; i < 5; i++) begin
                        c = crc16_step(c, rsp[i]);
                        if (keep) push_reply(rsp[i], 1'b0);
                    end
                    if (keep) begin
                        push_reply(c[7:0], 1'b0);
                        push_reply(c[15:8], 1'b1);
                    end
                end else if (head_copy[1] == FN_WRITE) begin
                    regs_copy[reg_no] = {head_copy[4], head_copy[5]};
                    for (int i = 0; i < 8; i++) begin
                        if (keep) push_reply(head_copy[i], i == 7);
                    end
                end
            end
            frame_cnt = 0;
            tail_copy = 16'h0000;
            crc_copy  = CRC_INIT;
        end
    endfunction

    function automatic void build_frame(input t_frame_row row);
        logic [7:0]  hdr [6];
        logic [15:0] c;
        int          body;
        hdr = '{row.addr, row.fn, row.reg_idx[15:8], row.reg_idx[7:0],
                row.data[15:8], row.data[7:0]};
        frame_len = row.len;
        body = (frame_len >= 3) ? frame_len - 2 : frame_len;
        for (int i = 0; i < body; i++) begin
            frame_bytes[i] = (i < 6) ? hdr[i] : 8'($urandom);
        end
        if (frame_len >= 3) begin
            c = CRC_INIT;
            for (int i = 0; i < body; i++) begin
                c = crc16_step(c, frame_bytes[i]);
            end
            if (!row.crc_ok) begin
                c = c ^ (16'h0001 << $urandom_range(15));
            end
            frame_bytes[body]     = c[7:0];
            frame_bytes[body + 1] = c[15:8];
        end
        frame_close = row.close_flag;
    endfunction

    // mostly well-formed requests with random content; the rest is noise
    function automatic void random_frame();
        t_frame_row row;
        int         pick;
        int         sel;
        pick = $urandom_range(99);
        if (pick < 15) begin
            frame_len = $urandom_range(1, 12);
            for (int i = 0; i < frame_len; i++) begin
                frame_bytes[i] = 8'($urandom);
            end
            frame_close = 1'b1;
        end else begin
            sel = $urandom_range(19);
            row.addr    = ($urandom_range(9) == 0) ? 8'($urandom) : station_addr;
            row.fn      = (sel < 9) ? FN_READ : (sel < 18) ? FN_WRITE : 8'($urandom);
            row.reg_idx = ($urandom_range(7) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(NUM_REGS - 1));
            if (row.fn == FN_READ) begin
                row.data = ($urandom_range(7) == 0) ? 16'($urandom) : 16'h0001;
            end else begin
                row.data = 16'($urandom);
            end
            sel = $urandom_range(99);
            if (sel < 84) begin
                row.len = 7'd8;
            end else if (sel < 94) begin
                row.len = 7'($urandom_range(9, 16));
            end else if (sel < 97) begin
                row.len = 7'(MAX_FRAME);
            end else begin
                row.len = 7'($urandom_range(3, 7));
            end
            row.crc_ok     = ($urandom_range(9) != 0);
            row.close_flag = (row.len != MAX_FRAME) || ($urandom_range(1) == 1);
            row.src        = REPLY_MODEL;
            build_frame(row);
        end
    endfunction

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_reply_src src);
        t_in_word w;
        for (int i = 0; i < frame_len; i++) begin
            w.rx_byte   = frame_bytes[i];
            w.frame_end = (i == frame_len - 1) && frame_close;
            if (src == REPLY_ECHO && i == frame_len - 1) begin
                for (int j = 0; j < 8; j++) begin
                    push_reply(frame_bytes[j], j == 7);
                end
            end
            absorb_rx_byte(w.rx_byte, w.frame_end, src == REPLY_MODEL);
            send_word(w);
        end
    endtask

    task automatic run_random(input int byte_goal);
        int sent;
        sent = 0;
        while (sent < byte_goal) begin
            random_frame();
            send_frame(REPLY_MODEL);
            sent += frame_len;
        end
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (reply_due_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_station_addr(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        station_addr = value;
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reply_due_q.size() == 0) begin
                $error("tx_byte: expected none, got %02h", o_out_word.tx_byte);
                err_count++;
            end else begin
                due = reply_due_q.pop_front();
                if (o_out_word.tx_byte !== due.tx_byte) begin
                    $error("tx_byte: expected %02h, got %02h", due.tx_byte, o_out_word.tx_byte);
                    err_count++;
                end
                if (o_out_word.last_byte !== due.last_byte) begin
                    $error("last_byte: expected %0b, got %0b", due.last_byte,
                           o_out_word.last_byte);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        station_addr = 8'h01;
        frame_cnt    = 0;
        tail_copy    = 16'h0000;
        crc_copy     = CRC_INIT;
        for (int i = 0; i < NUM_REGS; i++) begin
            regs_copy[i] = 16'h0000;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct = 18;
        snk_idle_pct = 87;
        for (int r = 0; r < PLAN_ROWS; r++) begin
            build_frame(PLAN[r]);
            send_frame(PLAN[r].src);
        end
        drain_replies();

        write_station_addr(8'h00);
        src_idle_pct = 87;
        snk_idle_pct = 18;
        run_random(12);
        drain_replies();

        write_station_addr(8'hFF);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(12);
        drain_replies();

        write_station_addr(8'($urandom_range(1, 254)));
        run_random(12);
        drain_replies();

        if (err_count == 0 && reply_due_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/mbrtu_pkg.sv
sv/modbus_rtu_holding_register_slave_unit.sv
sv/mbrtu_checker.sv
tb/sv/tb_top.sv
